[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/lmd_pkg.sv]
// Shared types and constants of the LED matrix frame driver.
`timescale 1ns / 1ps
package lmd_pkg;

    localparam int DEVICES_DEF = 4;
    localparam int QDEPTH      = 2;
    localparam int ROW_W       = 3;
    localparam int OP_W        = 4;

    // Back end operations
    localparam logic [OP_W-1:0] OP_REFRESH = 4'd0;
    localparam logic [OP_W-1:0] OP_WRITE   = 4'd1;
    localparam logic [OP_W-1:0] OP_STORE   = 4'd2;
    localparam logic [OP_W-1:0] OP_FILL    = 4'd3;
    localparam logic [OP_W-1:0] OP_ORCOL   = 4'd4;
    localparam logic [OP_W-1:0] OP_CLRDEV  = 4'd5;
    localparam logic [OP_W-1:0] OP_CLRALL  = 4'd6;
    localparam logic [OP_W-1:0] OP_INIT    = 4'd7;
    localparam logic [OP_W-1:0] OP_TEST    = 4'd8;

    typedef struct packed {
        logic [3:0]        req_type;
        logic [1:0]        device_index;
        logic signed [7:0] row_index;
        logic signed [7:0] col_index;
        logic [7:0]        pattern;
        logic signed [7:0] shift_amount;
        logic              symbol_done;
        logic              test_on;
    } in_t;

    typedef struct packed {
        logic [3:0] reg_address;
        logic [7:0] reg_value;
        logic       release_select;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [1:0]       dev;
        logic [ROW_W-1:0] row;
        logic [7:0]       data;
        logic [7:0]       mask;
    } cmd_t;

endpackage

[hw/rtl/lmd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/lmd_front.sv]
// Request front end: accept handshake, clamping, shifting and classification.
`timescale 1ns / 1ps
module lmd_front #(
    parameter int DEVICES = lmd_pkg::DEVICES_DEF
) (
    input  logic                         start,
    output logic                         busy,
    input  lmd_pkg::in_t                 request,
    input  logic [$clog2(DEVICES+1)-1:0] n_active,
    input  logic                         q_full,
    output logic                         q_push,
    output lmd_pkg::cmd_t                q_cmd
);
    import lmd_pkg::*;

    localparam int CNT_W = $clog2(DEVICES + 1);

    localparam logic [3:0] REQ_PIXEL    = 4'd0;
    localparam logic [3:0] REQ_COLUMN   = 4'd1;
    localparam logic [3:0] REQ_ROW      = 4'd2;
    localparam logic [3:0] REQ_CUST_COL = 4'd3;
    localparam logic [3:0] REQ_CUST_ROW = 4'd4;
    localparam logic [3:0] REQ_CLR_DEV  = 4'd5;
    localparam logic [3:0] REQ_CLR_ALL  = 4'd6;
    localparam logic [3:0] REQ_SYMBOL   = 4'd7;
    localparam logic [3:0] REQ_INIT     = 4'd8;
    localparam logic [3:0] REQ_TEST     = 4'd9;

    function automatic logic [ROW_W-1:0] clamp07(logic signed [7:0] v);
        logic [ROW_W-1:0] res;
        if (v[7])
            res = '0;
        else if (|v[6:3])
            res = '1;
        else
            res = v[2:0];
        return res;
    endfunction

    // Saturate the shift to -7..7; left loses the top bits
    function automatic logic [7:0] shift_byte(logic [7:0] p, logic signed [7:0] s);
        logic signed [7:0] neg;
        logic [7:0]        res;
        neg = -s;
        if (s > 8'sd7)
            res = p << 3'd7;
        else if (s > 8'sd0)
            res = p << s[2:0];
        else if (s < -8'sd7)
            res = p >> 3'd7;
        else if (s < 8'sd0)
            res = p >> neg[2:0];
        else
            res = p;
        return res;
    endfunction

    logic [ROW_W-1:0] row_c;
    logic [ROW_W-1:0] col_c;
    logic [7:0]       col_bit;
    logic [7:0]       shifted;
    logic             dev_ok;
    logic             keep;

    assign row_c   = clamp07(request.row_index);
    assign col_c   = clamp07(request.col_index);
    assign col_bit = 8'h01 << col_c;
    assign shifted = shift_byte(request.pattern, request.shift_amount);
    assign dev_ok  = ((CNT_W + 2)'(request.device_index) < (CNT_W + 2)'(n_active));

    always_comb
    begin
        q_cmd      = '0;
        q_cmd.dev  = request.device_index;
        q_cmd.row  = row_c;
        q_cmd.data = col_bit;
        q_cmd.mask = shifted;
        q_cmd.op   = OP_REFRESH;
        keep       = 1'b1;
        unique case (request.req_type)
            REQ_PIXEL:    q_cmd.op = dev_ok ? OP_WRITE : OP_REFRESH;
            REQ_COLUMN:   q_cmd.op = dev_ok ? OP_FILL : OP_REFRESH;
            REQ_ROW:
            begin
                q_cmd.op   = dev_ok ? OP_WRITE : OP_REFRESH;
                q_cmd.data = 8'hFF;
            end
            REQ_CUST_COL: q_cmd.op = dev_ok ? OP_ORCOL : OP_REFRESH;
            REQ_CUST_ROW:
            begin
                q_cmd.op   = dev_ok ? OP_WRITE : OP_REFRESH;
                q_cmd.data = shifted;
            end
            REQ_CLR_DEV:  q_cmd.op = dev_ok ? OP_CLRDEV : OP_REFRESH;
            REQ_CLR_ALL:  q_cmd.op = OP_CLRALL;
            REQ_SYMBOL:
            begin
                q_cmd.data = request.pattern;
                if (request.symbol_done)
                    q_cmd.op = dev_ok ? OP_WRITE : OP_REFRESH;
                else if (dev_ok)
                    q_cmd.op = OP_STORE;
                else
                    keep = 1'b0;
            end
            REQ_INIT:     q_cmd.op = OP_INIT;
            REQ_TEST:
            begin
                q_cmd.op   = OP_TEST;
                q_cmd.data = {7'd0, request.test_on};
            end
            default:      keep = 1'b0;
        endcase
    end

    assign busy   = q_full;
    // Requests with no effect and no frames are dropped here
    assign q_push = start && !q_full && keep;
endmodule

[hw/rtl/lmd_queue.sv]
// Short command queue between front end and execution unit.
`timescale 1ns / 1ps
module lmd_queue #(
    parameter int DEPTH = lmd_pkg::QDEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lmd_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output lmd_pkg::cmd_t rdata
);
    import lmd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule

[hw/rtl/lmd_back.sv]
// Execution unit: frame store updates, refresh and register group emission.
`timescale 1ns / 1ps
module lmd_back #(
    parameter int DEVICES = lmd_pkg::DEVICES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  lmd_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    input  logic [$clog2(DEVICES+1)-1:0] n_active,
    output lmd_pkg::out_t                result,
    output logic                         result_strobe
);
    import lmd_pkg::*;

    localparam int CNT_W = $clog2(DEVICES + 1);
    localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int AW    = ROW_W + DEV_W;
    localparam int DEPTH = 1 << AW;

    localparam logic [3:0] REG_DECODE   = 4'h9;
    localparam logic [3:0] REG_SCAN     = 4'hB;
    localparam logic [3:0] REG_SHUTDOWN = 4'hC;
    localparam logic [3:0] REG_TEST     = 4'hF;
    localparam int         INIT_GROUPS  = 5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_ORD  = 3'd2;
    localparam logic [2:0] S_ORW  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_GRP  = 3'd5;

    // Init sequence: test off, scan all digits, no decode, wake up, test off
    function automatic logic [11:0] init_frame(logic [2:0] g);
        logic [11:0] f;
        unique case (g)
            3'd0:    f = {REG_TEST, 8'h00};
            3'd1:    f = {REG_SCAN, 8'h07};
            3'd2:    f = {REG_DECODE, 8'h00};
            3'd3:    f = {REG_SHUTDOWN, 8'h01};
            default: f = {REG_TEST, 8'h00};
        endcase
        return f;
    endfunction

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [DEV_W-1:0] dev_reg;
    logic [DEV_W-1:0] dev_next;
    logic [2:0]       grp_reg;
    logic [2:0]       grp_next;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             p1_act_reg;
    logic             p1_act_next;
    logic [ROW_W-1:0] p1_row_reg;
    logic [ROW_W-1:0] p1_row_next;
    logic             p1_rel_reg;
    logic             p1_rel_next;
    logic             p1_last_reg;
    logic             p1_last_next;
    logic             p1_ent_reg;
    logic             p1_ent_next;
    out_t             out_reg;
    out_t             out_next;
    logic             strobe_reg;
    logic             strobe_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;
    logic [DEV_W-1:0] cdev;
    logic [DEV_W-1:0] last_dev;
    logic             dev_wrap;
    logic             grp_emit;
    logic [11:0]      grp_frame;
    logic             grp_last;

    assign cdev     = DEV_W'(cmd_reg.dev);
    assign last_dev = DEV_W'(n_active - CNT_W'(1));
    assign dev_wrap = (dev_reg == last_dev);

    lmd_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        row_next     = row_reg;
        dev_next     = dev_reg;
        grp_next     = grp_reg;
        vld_next     = vld_reg;
        p1_act_next  = 1'b0;
        p1_row_next  = row_reg;
        p1_rel_next  = dev_wrap;
        p1_last_next = dev_wrap && (row_reg == '1);
        p1_ent_next  = 1'b0;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = {row_reg, cdev};
        ram_wdata    = cmd_reg.data;
        ram_raddr    = {row_reg, cdev};
        grp_emit     = 1'b0;
        grp_frame    = {REG_TEST, cmd_reg.data};
        grp_last     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                row_next = '0;
                dev_next = '0;
                grp_next = '0;
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.op) inside
                        OP_REFRESH:                   state_next = S_EMIT;
                        OP_ORCOL:                     state_next = S_ORD;
                        OP_INIT, OP_TEST:             state_next = S_GRP;
                        OP_WRITE, OP_STORE, OP_FILL,
                        OP_CLRDEV, OP_CLRALL:         state_next = S_UPD;
                        default:                      state_next = S_IDLE;
                    endcase
                end
            end
            S_UPD:
            begin
                state_next = S_EMIT;
                unique case (cmd_reg.op) inside
                    OP_WRITE, OP_STORE:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = {cmd_reg.row, cdev};
                        vld_next[{cmd_reg.row, cdev}] = 1'b1;
                        if (cmd_reg.op == OP_STORE)
                            state_next = S_IDLE;
                    end
                    OP_FILL:
                    begin
                        ram_we = 1'b1;
                        vld_next[{row_reg, cdev}] = 1'b1;
                        row_next = row_reg + ROW_W'(1);
                        if (row_reg != '1)
                            state_next = S_UPD;
                    end
                    OP_CLRDEV:
                    begin
                        for (int r = 0; r < (1 << ROW_W); r++)
                        begin
                            vld_next[{ROW_W'(r), cdev}] = 1'b0;
                        end
                    end
                    default: vld_next = '0;
                endcase
            end
            S_ORD:
            begin
                state_next = S_ORW;
            end
            S_ORW:
            begin
                // Read data from the previous cycle; stale entries read as zero
                ram_we    = cmd_reg.mask[row_reg];
                ram_wdata = (vld_reg[{row_reg, cdev}] ? ram_rdata : 8'h00) | cmd_reg.data;
                if (cmd_reg.mask[row_reg])
                    vld_next[{row_reg, cdev}] = 1'b1;
                row_next   = row_reg + ROW_W'(1);
                state_next = (row_reg == '1) ? S_EMIT : S_ORD;
            end
            S_EMIT:
            begin
                ram_raddr   = {row_reg, dev_reg};
                p1_act_next = 1'b1;
                p1_ent_next = vld_reg[{row_reg, dev_reg}];
                if (dev_wrap)
                begin
                    dev_next = '0;
                    row_next = row_reg + ROW_W'(1);
                    if (row_reg == '1)
                        state_next = S_IDLE;
                end
                else
                begin
                    dev_next = dev_reg + DEV_W'(1);
                end
            end
            S_GRP:
            begin
                grp_emit = 1'b1;
                if (cmd_reg.op == OP_INIT)
                begin
                    grp_frame = init_frame(grp_reg);
                    grp_last  = dev_wrap && (grp_reg == 3'(INIT_GROUPS - 1));
                end
                else
                begin
                    grp_last = dev_wrap;
                end
                if (dev_wrap)
                begin
                    dev_next = '0;
                    grp_next = grp_reg + 3'd1;
                    if (grp_last)
                        state_next = S_IDLE;
                end
                else
                begin
                    dev_next = dev_reg + DEV_W'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output word, registered: refresh frames use store read data in the p1 stage
    always_comb
    begin
        out_next    = out_reg;
        strobe_next = 1'b0;
        if (p1_act_reg)
        begin
            strobe_next             = 1'b1;
            out_next.reg_address    = {1'b0, p1_row_reg} + 4'd1;
            out_next.reg_value      = p1_ent_reg ? ram_rdata : 8'h00;
            out_next.release_select = p1_rel_reg;
            out_next.last           = p1_last_reg;
        end
        else if (grp_emit)
        begin
            strobe_next             = 1'b1;
            out_next.reg_address    = grp_frame[11:8];
            out_next.reg_value      = grp_frame[7:0];
            out_next.release_select = dev_wrap;
            out_next.last           = grp_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            row_reg    <= '0;
            dev_reg    <= '0;
            grp_reg    <= '0;
            vld_reg    <= '0;
            p1_act_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            dev_reg    <= dev_next;
            grp_reg    <= grp_next;
            vld_reg    <= vld_next;
            p1_act_reg <= p1_act_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        p1_row_reg  <= p1_row_next;
        p1_rel_reg  <= p1_rel_next;
        p1_last_reg <= p1_last_next;
        p1_ent_reg  <= p1_ent_next;
        out_reg     <= out_next;
    end

    assign result        = out_reg;
    assign result_strobe = strobe_reg;
endmodule

[hw/rtl/led_matrix_chain_frame_driver.sv]
// Top level of the LED matrix chain frame driver.
`timescale 1ns / 1ps
// Usage:
//   Request channel: a word on request is taken at a clock edge with start high
//   and busy low. Up to two requests wait in a queue ahead of the execution unit;
//   busy is high while that queue is full.
//   Config channel: cfg_data (active chip count) is written when cfg_valid is
//   high; cfg_ready is always high. Write it only while no request is pending.
//   Result channel: each frame word is on result for one cycle with
//   result_strobe high; the receiver cannot hold results off.
//   Operation: store updates (pixel, row, column, custom, clear, symbol) run
//   first; each such request, like a plain refresh, then emits every row for
//   each active chip, while init and display test emit register groups. Frames
//   leave one per cycle, paced by the single read port of the frame store.
//   A pending symbol row only updates the frame store and gives no frames.
//   Reset: frame store reads as all zero (per-entry valid bits clear at once,
//   no clearing pass), active count returns to 4, queue empties.
module led_matrix_chain_frame_driver #(
    parameter int DEVICES = lmd_pkg::DEVICES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lmd_pkg::in_t  request,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_data,
    output lmd_pkg::out_t result,
    output logic          result_strobe
);
    import lmd_pkg::*;

    localparam int CNT_W = $clog2(DEVICES + 1);

    logic [2:0]       active_reg;
    logic [2:0]       active_next;
    logic [CNT_W-1:0] n_active;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    cmd_t             q_wcmd;
    cmd_t             q_rcmd;

    assign cfg_ready   = 1'b1;
    assign active_next = (cfg_valid && cfg_ready) ? cfg_data : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 3'd4;
        else
            active_reg <= active_next;
    end

    // Zero counts as one chip, anything above the chain length saturates
    always_comb
    begin
        if (active_reg == 3'd0)
            n_active = CNT_W'(1);
        else if (32'(active_reg) > DEVICES)
            n_active = CNT_W'(DEVICES);
        else
            n_active = CNT_W'(active_reg);
    end

    lmd_front #(
        .DEVICES(DEVICES)
    ) u_front (
        .start   (start),
        .busy    (busy),
        .request (request),
        .n_active(n_active),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_wcmd)
    );

    lmd_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wcmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_valid),
        .rdata    (q_rcmd)
    );

    lmd_back #(
        .DEVICES(DEVICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_rcmd),
        .q_pop        (q_pop),
        .n_active     (n_active),
        .result       (result),
        .result_strobe(result_strobe)
    );
endmodule

[hw/rtl/lmd_checker.sv]
// Port-level checks on the frame driver's result stream, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lmd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          result_strobe,
    input lmd_pkg::out_t result
);
    // The final word of a request always closes a select window
    `AM_ASSERT_IMP(a_last_releases, clk, rst_n, result_strobe && result.last, result.release_select)

    // Words of one request leave back to back
    `AM_ASSERT_NXT(a_burst_gapless, clk, rst_n, result_strobe && !result.last, result_strobe)

    // Within one select window the register address holds
    `AM_ASSERT_NXT(a_window_addr, clk, rst_n, result_strobe && !result.release_select,
        result.reg_address == $past(result.reg_address))
endmodule

bind led_matrix_chain_frame_driver lmd_checker u_lmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_strobe(result_strobe),
    .result       (result)
);

[tb/sv/testbench.sv]
// Testbench for the LED matrix chain frame driver: directed and random requests, predicted frames.
`timescale 1ns / 1ps
module testbench;
    import lmd_pkg::*;

    typedef enum logic [3:0] {
        REQ_PIXEL      = 4'd0,
        REQ_COLUMN     = 4'd1,
        REQ_ROW        = 4'd2,
        REQ_CUSTOM_COL = 4'd3,
        REQ_CUSTOM_ROW = 4'd4,
        REQ_CLEAR_DEV  = 4'd5,
        REQ_CLEAR_ALL  = 4'd6,
        REQ_SYMBOL_ROW = 4'd7,
        REQ_INIT       = 4'd8,
        REQ_TEST       = 4'd9
    } req_e;

    localparam int          REQ_CODE_MAX  = 15;
    localparam logic [3:0]  ADDR_DECODE   = 4'h9;
    localparam logic [3:0]  ADDR_SCAN_LIM = 4'hB;
    localparam logic [3:0]  ADDR_SHUTDOWN = 4'hC;
    localparam logic [3:0]  ADDR_TEST     = 4'hF;
    localparam int          MAX_INDEX     = 7;
    localparam int          ROWS          = 8;
    localparam int          CHIPS         = DEVICES_DEF;
    localparam logic [2:0]  CHIPS_RESET   = 3'd4;
    localparam int          RANDOM_ITEMS  = 175;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          LIMIT_CYCLES  = 500000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    in_t          request = '0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_data = '0;
    out_t         result;
    logic         result_strobe;

    // predictor state
    logic [7:0]   panel_rows [ROWS][CHIPS];
    logic [2:0]   chip_count_reg = CHIPS_RESET;
    out_t         request_frames [$];
    out_t         pending_frames [$];

    int           error_count = 0;
    int           request_count = 0;
    int           ignored_count = 0;
    int           frames_checked = 0;
    int           config_writes = 0;
    int           cycle_count = 0;
    bit           no_gaps = 1'b0;

    led_matrix_chain_frame_driver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result        (result),
        .result_strobe (result_strobe)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int effective_chips();
        int n;
        n = int'(chip_count_reg);
        if (n < 1) n = 1;
        if (n > CHIPS) n = CHIPS;
        return n;
    endfunction

    function automatic int clamp_index(logic signed [7:0] v);
        if (v < 0) return 0;
        if (v > MAX_INDEX) return MAX_INDEX;
        return int'(v);
    endfunction

    function automatic logic [7:0] shift_pattern(logic [7:0] p, logic signed [7:0] s);
        int k;
        k = int'(s);
        if (k > MAX_INDEX) k = MAX_INDEX;
        if (k < -MAX_INDEX) k = -MAX_INDEX;
        if (k > 0) return p << k;
        if (k < 0) return p >> (-k);
        return p;
    endfunction

    function automatic void add_frame(logic [3:0] addr, logic [7:0] val, logic rel);
        out_t f;
        f.reg_address    = addr;
        f.reg_value      = val;
        f.release_select = rel;
        f.last           = 1'b0;
        request_frames.push_back(f);
    endfunction

    function automatic void add_group(logic [3:0] addr, logic [7:0] val, int n);
        for (int j = 0; j < n; j++) add_frame(addr, val, j == n - 1);
    endfunction

    // update the shadow store and queue the frames one request causes
    function automatic void predict_frames(in_t req);
        int n;
        int r;
        int c;
        logic ok;
        logic [7:0] bits;
        logic [7:0] one_hot;
        n = effective_chips();
        r = clamp_index(req.row_index);
        c = clamp_index(req.col_index);
        ok = int'(req.device_index) < n;
        bits = shift_pattern(req.pattern, req.shift_amount);
        one_hot = 8'd1 << c;
        request_frames.delete();
        case (req.req_type)
            REQ_PIXEL:      if (ok) panel_rows[r][req.device_index] = one_hot;
            REQ_COLUMN:     if (ok) for (int i = 0; i < ROWS; i++)
                                panel_rows[i][req.device_index] = one_hot;
            REQ_ROW:        if (ok) panel_rows[r][req.device_index] = 8'hFF;
            REQ_CUSTOM_COL: if (ok) for (int i = 0; i < ROWS; i++)
                                if (bits[i]) panel_rows[i][req.device_index] |= one_hot;
            REQ_CUSTOM_ROW: if (ok) panel_rows[r][req.device_index] = bits;
            REQ_CLEAR_DEV:  if (ok) for (int i = 0; i < ROWS; i++)
                                panel_rows[i][req.device_index] = 8'h00;
            REQ_CLEAR_ALL:  for (int i = 0; i < ROWS; i++)
                                for (int j = 0; j < CHIPS; j++) panel_rows[i][j] = 8'h00;
            REQ_SYMBOL_ROW:
            begin
                if (ok) panel_rows[r][req.device_index] = req.pattern;
                if (!req.symbol_done) return;
            end
            REQ_INIT, REQ_TEST: ;
            default: return;
        endcase
        if (req.req_type == REQ_INIT)
        begin
            add_group(ADDR_TEST, 8'h00, n);
            add_group(ADDR_SCAN_LIM, 8'(MAX_INDEX), n);
            add_group(ADDR_DECODE, 8'h00, n);
            add_group(ADDR_SHUTDOWN, 8'h01, n);
            add_group(ADDR_TEST, 8'h00, n);
        end
        else if (req.req_type == REQ_TEST)
            add_group(ADDR_TEST, {7'd0, req.test_on}, n);
        else
            for (int i = 0; i < ROWS; i++)
                for (int j = 0; j < n; j++)
                    add_frame(4'(i + 1), panel_rows[i][j], j == n - 1);
        request_frames[request_frames.size() - 1].last = 1'b1;
        foreach (request_frames[k]) pending_frames.push_back(request_frames[k]);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t make_request(req_e kind, logic [1:0] dev, logic [7:0] row,
                                         logic [7:0] col, logic [7:0] pat,
                                         logic [7:0] sh, logic done, logic on);
        in_t req;
        req.req_type     = kind;
        req.device_index = dev;
        req.row_index    = row;
        req.col_index    = col;
        req.pattern      = pat;
        req.shift_amount = sh;
        req.symbol_done  = done;
        req.test_on      = on;
        return req;
    endfunction

    function automatic in_t random_request();
        in_t req;
        req.req_type = ($urandom_range(0, 99) < 8)
            ? 4'($urandom_range(int'(REQ_TEST) + 1, REQ_CODE_MAX))
            : 4'($urandom_range(int'(REQ_PIXEL), int'(REQ_TEST)));
        req.device_index = 2'($urandom_range(0, 3));
        req.row_index    = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7))
                                                       : 8'($urandom_range(0, 255));
        req.col_index    = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7))
                                                       : 8'($urandom_range(0, 255));
        req.pattern      = 8'($urandom_range(0, 255));
        req.shift_amount = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 16) - 8)
                                                       : 8'($urandom_range(0, 255));
        req.symbol_done  = $urandom_range(0, 3) != 0;
        req.test_on      = 1'($urandom_range(0, 1));
        return req;
    endfunction

    // one request word, held until taken with busy low
    task automatic send_request(input in_t req);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request <= req;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        predict_frames(req);
        if (req.req_type > REQ_TEST) ignored_count++;
        else request_count++;
    endtask

    task automatic drain_frames();
        @(negedge clk);
        start <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        // queued requests with no frames may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_chip_count(input logic [2:0] value);
        drain_frames();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        chip_count_reg = value;
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // eight-row symbol sequence: seven pending rows then the one that refreshes
    task automatic send_symbol(input logic [1:0] dev);
        for (int i = 0; i < ROWS; i++)
            send_request(make_request(REQ_SYMBOL_ROW, dev, 8'(i), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      i == ROWS - 1, 1'($urandom_range(0, 1))));
    endtask

    task automatic test_directed_requests();
        write_chip_count(CHIPS_RESET);
        send_request(make_request(REQ_PIXEL, 2'd0, 8'h80, 8'h7F, 8'h00, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_PIXEL, 2'd3, 8'h7F, 8'h80, 8'hFF, 8'hFF, 1'b0, 1'b1));
        send_request(make_request(REQ_COLUMN, 2'd1, 8'h02, 8'h03, 8'h00, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_ROW, 2'd2, 8'h05, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0));
        // shift clamps to +7 and -7
        send_request(make_request(REQ_CUSTOM_COL, 2'd0, 8'h00, 8'h07, 8'hA5, 8'h7F, 1'b1, 1'b0));
        send_request(make_request(REQ_CUSTOM_COL, 2'd3, 8'h00, 8'h00, 8'hFF, 8'h80, 1'b1, 1'b0));
        send_request(make_request(REQ_CUSTOM_COL, 2'd1, 8'h00, 8'h04, 8'h3C, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_CUSTOM_ROW, 2'd2, 8'h00, 8'h00, 8'h81, 8'h03, 1'b1, 1'b0));
        send_request(make_request(REQ_CUSTOM_ROW, 2'd2, 8'h07, 8'h00, 8'hF0, 8'hFD, 1'b1, 1'b0));
        send_request(make_request(REQ_CUSTOM_ROW, 2'd1, 8'h03, 8'h00, 8'h55, 8'h08, 1'b1, 1'b0));
        send_request(make_request(REQ_CUSTOM_ROW, 2'd0, 8'h04, 8'h00, 8'hC3, 8'hF8, 1'b1, 1'b0));
        send_request(make_request(REQ_SYMBOL_ROW, 2'd0, 8'h00, 8'h00, 8'h18, 8'h00, 1'b0, 1'b0));
        send_request(make_request(REQ_SYMBOL_ROW, 2'd0, 8'h01, 8'h00, 8'h24, 8'h00, 1'b0, 1'b0));
        send_request(make_request(REQ_SYMBOL_ROW, 2'd0, 8'h02, 8'h00, 8'h42, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_SYMBOL_ROW, 2'd3, 8'hF0, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1));
        send_request(make_request(req_e'(4'd10), 2'd1, 8'h01, 8'h01, 8'h11, 8'h01, 1'b1, 1'b1));
        send_request(make_request(req_e'(4'(REQ_CODE_MAX)), 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                  1'b1, 1'b1));
        send_request(make_request(REQ_CLEAR_DEV, 2'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_TEST, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_request(make_request(REQ_TEST, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_INIT, 2'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_CLEAR_ALL, 2'd2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_request(make_request(REQ_PIXEL, 2'd3, 8'h07, 8'h07, 8'hFF, 8'h7F, 1'b1, 1'b1));
        drain_frames();
    endtask

    // every chip count, including 0 and the values above the chain length
    task automatic test_chip_count_sweep();
        logic [2:0] counts [8] = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
        foreach (counts[k])
        begin
            write_chip_count(counts[k]);
            no_gaps = k[0];
            // device 3 leaves the store alone when it is beyond the active count
            send_request(make_request(REQ_ROW, 2'd3, 8'h06, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
            send_request(make_request(REQ_INIT, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
            repeat (4) send_request(random_request());
        end
        no_gaps = 1'b0;
        drain_frames();
    endtask

    task automatic test_random_traffic();
        int sent;
        in_t req;
        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_chip_count(3'($urandom_range(0, 7)));
            no_gaps = (phase == 2);
            for (int k = 0; k < RANDOM_ITEMS / 5; )
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    send_symbol(2'($urandom_range(0, 3)));
                    k += ROWS;
                end
                else
                begin
                    req = random_request();
                    send_request(req);
                    if (req.req_type <= REQ_TEST) k++;
                end
            end
        end
        no_gaps = 1'b0;
        drain_frames();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected frame addr %0h value %02h release %0b last %0b",
                         $time, result.reg_address, result.reg_value,
                         result.release_select, result.last);
                error_count++;
            end
            else
            begin
                out_t want;
                want = pending_frames.pop_front();
                frames_checked++;
                if (result.reg_address !== want.reg_address ||
                    result.reg_value !== want.reg_value ||
                    result.release_select !== want.release_select ||
                    result.last !== want.last)
                begin
                    $display("%0t: frame mismatch: expected addr %0h value %02h rel %0b last %0b",
                             $time, want.reg_address, want.reg_value,
                             want.release_select, want.last);
                    $display("%0t:                 actual   addr %0h value %02h rel %0b last %0b",
                             $time, result.reg_address, result.reg_value,
                             result.release_select, result.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d frames still expected", $time, pending_frames.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        foreach (panel_rows[i, j]) panel_rows[i][j] = 8'h00;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_requests();
        test_chip_count_sweep();
        test_random_traffic();

        $display("run covered %0d requests and %0d ignored codes over %0d chip count writes,",
                 request_count, ignored_count, config_writes);
        $display("with %0d frames checked and %0d mismatches", frames_checked, error_count);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
